[sv/keypad_code_lock_controller_macros.svh]
// Assertion macros shared by the keypad code lock controller modules.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define KCL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define KCL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define KCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/kcl_pkg.sv]
// Shared types, codes and constants of the keypad code lock controller.
package kcl_pkg;

  localparam int CODE_DIGITS_DEF = 6;
  localparam int TIMER_BITS_DEF  = 20;

  localparam int OPCODE_W    = 3;
  localparam int KEY_W       = 4;
  localparam int EV_W        = 3;
  localparam int PIN_W       = 24;
  localparam int TICKS_W     = 20;
  localparam int LIMIT_W     = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int S_TDATA_W   = 8;
  localparam int RES_BITS    = 9;
  localparam int M_TDATA_W   = 16;
  localparam int QDEPTH      = 2;

  localparam logic [PIN_W-1:0]   PIN_CODE_RST      = 24'd1193046;
  localparam logic [TICKS_W-1:0] UNLOCK_TICKS_RST  = 20'd15000;
  localparam logic [TICKS_W-1:0] LOCKOUT_TICKS_RST = 20'd60000;
  localparam logic [TICKS_W-1:0] TIMEOUT_TICKS_RST = 20'd30000;
  localparam logic [TICKS_W-1:0] ATTEMPT_TICKS_RST = 20'd120000;
  localparam logic [TICKS_W-1:0] HOLDOFF_TICKS_RST = 20'd80;
  localparam logic [LIMIT_W-1:0] PIN_LIMIT_RST     = 3'd3;
  localparam logic [LIMIT_W-1:0] FINGER_LIMIT_RST  = 3'd5;

  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_STAR      = 4'd10;
  localparam logic [KEY_W-1:0] KEY_HASH      = 4'd11;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK          = 3'd0,
    OP_KEY           = 3'd1,
    OP_FINGER_MATCH  = 3'd2,
    OP_FINGER_FAIL   = 3'd3,
    OP_REMOTE_UNLOCK = 3'd4,
    OP_REMOTE_LOCK   = 3'd5
  } op_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE            = 3'd0,
    EV_GRANTED         = 3'd1,
    EV_DENIED          = 3'd2,
    EV_LOCKOUT         = 3'd3,
    EV_RELOCKED        = 3'd4,
    EV_TIMEOUT         = 3'd5,
    EV_ALREADY_LOCKED  = 3'd6,
    EV_REMOTE_UNLOCKED = 3'd7
  } ev_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PIN_CODE      = 3'd0,
    REG_UNLOCK_TICKS  = 3'd1,
    REG_LOCKOUT_TICKS = 3'd2,
    REG_TIMEOUT_TICKS = 3'd3,
    REG_ATTEMPT_TICKS = 3'd4,
    REG_HOLDOFF_TICKS = 3'd5,
    REG_PIN_LIMIT     = 3'd6,
    REG_FINGER_LIMIT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    CMD_TICK,
    CMD_DIGIT,
    CMD_STAR,
    CMD_HASH,
    CMD_LETTER,
    CMD_FMATCH,
    CMD_FFAIL,
    CMD_RUNLOCK,
    CMD_RLOCK,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [KEY_W-1:0] digit;
    logic             level;
  } cmd_t;

endpackage

[sv/kcl_front.sv]
// Input stage: takes stream transfers and classifies them into commands.
module kcl_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [kcl_pkg::S_TDATA_W-1:0]  s_tdata,  // key_code[3:0], motion_level[4]
  input  logic [kcl_pkg::OPCODE_W-1:0]   s_tuser,  // opcode[2:0]
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output kcl_pkg::cmd_t                  cmd
);
  import kcl_pkg::*;

  logic [KEY_W-1:0] key;
  cmd_t             cmd_class;

  assign key      = s_tdata[KEY_W-1:0];
  assign s_tready = !cmd_valid || cmd_ready;

  always_comb begin
    cmd_class.digit = key;
    cmd_class.level = s_tdata[KEY_W];
    case (op_t'(s_tuser))
      OP_TICK:          cmd_class.kind = CMD_TICK;
      OP_KEY: begin
        if (key inside {[4'd0:KEY_DIGIT_MAX]}) begin
          cmd_class.kind = CMD_DIGIT;
        end else if (key == KEY_STAR) begin
          cmd_class.kind = CMD_STAR;
        end else if (key == KEY_HASH) begin
          cmd_class.kind = CMD_HASH;
        end else begin
          cmd_class.kind = CMD_LETTER;
        end
      end
      OP_FINGER_MATCH:  cmd_class.kind = CMD_FMATCH;
      OP_FINGER_FAIL:   cmd_class.kind = CMD_FFAIL;
      OP_REMOTE_UNLOCK: cmd_class.kind = CMD_RUNLOCK;
      OP_REMOTE_LOCK:   cmd_class.kind = CMD_RLOCK;
      default:          cmd_class.kind = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (s_tready) begin
      cmd_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_class;
    end
  end

endmodule

[sv/kcl_queue.sv]
// Short command queue between the input stage and the lock engine.
`include "keypad_code_lock_controller_macros.svh"
module kcl_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  kcl_pkg::cmd_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output kcl_pkg::cmd_t out_data
);
  import kcl_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             slot [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = count != CNT_W'(QDEPTH);
  assign out_valid = count != '0;
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

  `KCL_ASSERT_ALWAYS(a_count_range, count <= CNT_W'(QDEPTH), "queue count beyond depth")
  `KCL_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue count lost a push")
  `KCL_ASSERT_NEXT(a_empty_pass, push && (count == '0), out_data == $past(in_data), "queue head differs from the transfer written into an empty queue")

endmodule

[sv/kcl_back.sv]
// Lock engine: configuration registers, lock state, timers and the result register.
`include "keypad_code_lock_controller_macros.svh"
module kcl_back #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF,
  parameter int TIMER_BITS  = kcl_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [kcl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kcl_pkg::PIN_W-1:0]       cfg_data,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  kcl_pkg::cmd_t                   q_data,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kcl_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [kcl_pkg::EV_W-1:0]        m_tuser
);
  import kcl_pkg::*;

  localparam int DW = 4 * CODE_DIGITS;
  localparam int LW = $clog2(CODE_DIGITS + 1);
  localparam int CW = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  function automatic logic [TIMER_BITS-1:0] age_up(input logic [TIMER_BITS-1:0] v);
    return (v == TMAX) ? TMAX : v + 1'b1;
  endfunction

  function automatic logic [TIMER_BITS-1:0] as_timer(input logic [TICKS_W-1:0] v);
    return (CW'(v) > CW'(TMAX)) ? TMAX : TIMER_BITS'(v);
  endfunction

  logic [PIN_W-1:0]   pin_code;
  logic [TICKS_W-1:0] unlock_ticks;
  logic [TICKS_W-1:0] lockout_ticks;
  logic [TICKS_W-1:0] keypad_timeout_ticks;
  logic [TICKS_W-1:0] attempt_reset_ticks;
  logic [TICKS_W-1:0] motion_holdoff_ticks;
  logic [LIMIT_W-1:0] pin_attempt_limit;
  logic [LIMIT_W-1:0] finger_attempt_limit;

  logic                  bolt_locked,       bolt_locked_next;
  logic                  relock_armed,      relock_armed_next;
  logic [TIMER_BITS-1:0] relock_remaining,  relock_remaining_next;
  logic [TIMER_BITS-1:0] lockout_remaining, lockout_remaining_next;
  logic [DW-1:0]         entry_digits,      entry_digits_next;
  logic [LW-1:0]         entry_length,      entry_length_next;
  logic [TIMER_BITS-1:0] key_idle_age,      key_idle_age_next;
  logic [LIMIT_W-1:0]    code_fail_count,   code_fail_count_next;
  logic [TIMER_BITS-1:0] code_fail_age,     code_fail_age_next;
  logic [LIMIT_W-1:0]    print_fail_count,  print_fail_count_next;
  logic [TIMER_BITS-1:0] print_fail_age,    print_fail_age_next;
  logic                  motion_prev,       motion_prev_next;
  logic [TIMER_BITS-1:0] motion_age,        motion_age_next;

  logic [DW-1:0]         pin_digits;
  logic [TIMER_BITS-1:0] unlock_load;
  logic [TIMER_BITS-1:0] lockout_load;
  logic                  fire;
  logic                  open_for_input;
  logic                  fail_code;
  logic [LIMIT_W-1:0]    fail_cnt;
  logic [LIMIT_W-1:0]    fail_lim;
  logic [LIMIT_W-1:0]    fail_cnt1;
  logic                  fail_hit;
  logic [LIMIT_W-1:0]    fail_left;
  logic                  motion_rise;
  logic                  do_unlock;
  logic                  do_fail;
  logic                  clr;
  ev_t                   ev;
  logic [LIMIT_W-1:0]    left;

  assign pin_digits     = DW'(pin_code);
  assign unlock_load    = as_timer(unlock_ticks);
  assign lockout_load   = as_timer(lockout_ticks);
  assign q_ready        = !m_tvalid || m_tready;
  assign fire           = q_valid && q_ready;
  assign open_for_input = bolt_locked && (lockout_remaining == '0);
  assign fail_code      = q_data.kind == CMD_HASH;
  assign fail_cnt       = fail_code ? code_fail_count : print_fail_count;
  assign fail_lim       = fail_code ? pin_attempt_limit : finger_attempt_limit;
  assign fail_cnt1      = fail_cnt + 1'b1;
  assign fail_hit       = fail_cnt1 >= fail_lim;
  assign fail_left      = fail_lim - fail_cnt1;

  always_comb begin
    bolt_locked_next       = bolt_locked;
    relock_armed_next      = relock_armed;
    relock_remaining_next  = relock_remaining;
    lockout_remaining_next = lockout_remaining;
    entry_digits_next      = entry_digits;
    entry_length_next      = entry_length;
    key_idle_age_next      = key_idle_age;
    code_fail_count_next   = code_fail_count;
    code_fail_age_next     = code_fail_age;
    print_fail_count_next  = print_fail_count;
    print_fail_age_next    = print_fail_age;
    motion_prev_next       = motion_prev;
    motion_age_next        = motion_age;
    motion_rise            = 1'b0;
    do_unlock              = 1'b0;
    do_fail                = 1'b0;
    clr                    = 1'b0;
    ev                     = EV_NONE;
    left                   = '0;

    case (q_data.kind)
      CMD_TICK: begin
        key_idle_age_next   = age_up(key_idle_age);
        code_fail_age_next  = age_up(code_fail_age);
        print_fail_age_next = age_up(print_fail_age);
        motion_age_next     = age_up(motion_age);
        if (code_fail_count != '0 && CW'(code_fail_age_next) > CW'(attempt_reset_ticks)) begin
          code_fail_count_next = '0;
        end
        if (print_fail_count != '0 &&
            CW'(print_fail_age_next) > CW'(attempt_reset_ticks)) begin
          print_fail_count_next = '0;
        end
        if (lockout_remaining != '0) begin
          lockout_remaining_next = lockout_remaining - 1'b1;
          if (lockout_remaining_next == '0) begin
            clr = 1'b1;
          end
        end
        motion_rise = !motion_prev && q_data.level &&
                      (CW'(motion_age_next) > CW'(motion_holdoff_ticks));
        motion_prev_next = q_data.level;
        if (motion_rise) begin
          motion_age_next = '0;
        end
        if (relock_armed) begin
          if (motion_rise) begin
            relock_remaining_next = unlock_load;
          end else if (relock_remaining <= TIMER_BITS'(1)) begin
            relock_remaining_next = '0;
            relock_armed_next     = 1'b0;
            bolt_locked_next      = 1'b1;
            clr                   = 1'b1;
            ev                    = EV_RELOCKED;
          end else begin
            relock_remaining_next = relock_remaining - 1'b1;
          end
        end
        if (ev == EV_NONE && bolt_locked_next && lockout_remaining_next == '0 && !clr &&
            entry_length != '0 && CW'(key_idle_age_next) >= CW'(keypad_timeout_ticks)) begin
          clr = 1'b1;
          ev  = EV_TIMEOUT;
        end
      end
      CMD_DIGIT: begin
        if (open_for_input) begin
          key_idle_age_next = '0;
          if (entry_length < LW'(CODE_DIGITS)) begin
            entry_digits_next = {entry_digits[DW-5:0], q_data.digit};
            entry_length_next = entry_length + 1'b1;
          end
        end
      end
      CMD_STAR: begin
        if (open_for_input) begin
          key_idle_age_next = '0;
          if (entry_length != '0) begin
            entry_digits_next = entry_digits >> 4;
            entry_length_next = entry_length - 1'b1;
          end
        end
      end
      CMD_HASH: begin
        if (open_for_input) begin
          key_idle_age_next = '0;
          if (entry_length == LW'(CODE_DIGITS)) begin
            if (entry_digits == pin_digits) begin
              code_fail_count_next = '0;
              do_unlock            = 1'b1;
              ev                   = EV_GRANTED;
            end else begin
              do_fail = 1'b1;
            end
          end
        end
      end
      CMD_LETTER: begin
        if (open_for_input) begin
          key_idle_age_next = '0;
        end
      end
      CMD_FMATCH: begin
        if (open_for_input) begin
          print_fail_count_next = '0;
          do_unlock             = 1'b1;
          ev                    = EV_GRANTED;
        end
      end
      CMD_FFAIL: begin
        if (open_for_input) begin
          do_fail = 1'b1;
        end
      end
      CMD_RUNLOCK: begin
        lockout_remaining_next = '0;
        do_unlock              = 1'b1;
        ev                     = EV_REMOTE_UNLOCKED;
      end
      CMD_RLOCK: begin
        if (bolt_locked) begin
          ev = EV_ALREADY_LOCKED;
        end else begin
          bolt_locked_next      = 1'b1;
          relock_armed_next     = 1'b0;
          relock_remaining_next = '0;
          clr                   = 1'b1;
          ev                    = EV_RELOCKED;
        end
      end
      default: begin
      end
    endcase

    if (do_unlock) begin
      bolt_locked_next      = 1'b0;
      relock_armed_next     = 1'b1;
      relock_remaining_next = unlock_load;
      clr                   = 1'b1;
    end

    if (do_fail) begin
      clr = 1'b1;
      if (fail_hit) begin
        lockout_remaining_next = lockout_load;
        ev                     = EV_LOCKOUT;
      end else begin
        ev   = EV_DENIED;
        left = fail_left;
      end
      if (fail_code) begin
        code_fail_count_next = fail_hit ? '0 : fail_cnt1;
        code_fail_age_next   = '0;
      end else begin
        print_fail_count_next = fail_hit ? '0 : fail_cnt1;
        print_fail_age_next   = '0;
      end
    end

    if (clr) begin
      entry_digits_next = '0;
      entry_length_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_code             <= PIN_CODE_RST;
      unlock_ticks         <= UNLOCK_TICKS_RST;
      lockout_ticks        <= LOCKOUT_TICKS_RST;
      keypad_timeout_ticks <= TIMEOUT_TICKS_RST;
      attempt_reset_ticks  <= ATTEMPT_TICKS_RST;
      motion_holdoff_ticks <= HOLDOFF_TICKS_RST;
      pin_attempt_limit    <= PIN_LIMIT_RST;
      finger_attempt_limit <= FINGER_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_PIN_CODE:      pin_code             <= cfg_data;
        REG_UNLOCK_TICKS:  unlock_ticks         <= cfg_data[TICKS_W-1:0];
        REG_LOCKOUT_TICKS: lockout_ticks        <= cfg_data[TICKS_W-1:0];
        REG_TIMEOUT_TICKS: keypad_timeout_ticks <= cfg_data[TICKS_W-1:0];
        REG_ATTEMPT_TICKS: attempt_reset_ticks  <= cfg_data[TICKS_W-1:0];
        REG_HOLDOFF_TICKS: motion_holdoff_ticks <= cfg_data[TICKS_W-1:0];
        REG_PIN_LIMIT:     pin_attempt_limit    <= cfg_data[LIMIT_W-1:0];
        REG_FINGER_LIMIT:  finger_attempt_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bolt_locked       <= 1'b1;
      relock_armed      <= 1'b0;
      relock_remaining  <= '0;
      lockout_remaining <= '0;
      entry_digits      <= '0;
      entry_length      <= '0;
      key_idle_age      <= '0;
      code_fail_count   <= '0;
      code_fail_age     <= '0;
      print_fail_count  <= '0;
      print_fail_age    <= '0;
      motion_prev       <= 1'b0;
      motion_age        <= TMAX;
      m_tvalid          <= 1'b0;
    end else begin
      if (fire) begin
        bolt_locked       <= bolt_locked_next;
        relock_armed      <= relock_armed_next;
        relock_remaining  <= relock_remaining_next;
        lockout_remaining <= lockout_remaining_next;
        entry_digits      <= entry_digits_next;
        entry_length      <= entry_length_next;
        key_idle_age      <= key_idle_age_next;
        code_fail_count   <= code_fail_count_next;
        code_fail_age     <= code_fail_age_next;
        print_fail_count  <= print_fail_count_next;
        print_fail_age    <= print_fail_age_next;
        motion_prev       <= motion_prev_next;
        motion_age        <= motion_age_next;
        m_tvalid          <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tuser <= ev;
      m_tdata <= {{(M_TDATA_W - RES_BITS){1'b0}}, relock_armed_next, left,
                  3'(entry_length_next), lockout_remaining_next != '0, bolt_locked_next};
    end
  end

  `KCL_ASSERT_ALWAYS(a_lockout_locked, lockout_remaining == '0 || bolt_locked, "lockout running while the bolt is open")
  `KCL_ASSERT_ALWAYS(a_armed_open, relock_armed == !bolt_locked, "relock countdown out of step with the bolt")
  `KCL_ASSERT_ALWAYS(a_entry_len, entry_length <= LW'(CODE_DIGITS), "entry buffer holds too many digits")
  `KCL_ASSERT_IMPLY(a_denied_left, m_tvalid && m_tuser == EV_DENIED, m_tdata[7:5] != 3'd0, "denial reported with no attempts left")

endmodule

[sv/keypad_code_lock_controller.sv]
// Top level of the keypad code lock controller.
//
//   Port group   Direction   Carries
//   s_*          in          one command per transfer (tick, key, finger, remote)
//   m_*          out         one result per command (event and lock status)
//   cfg_*        in          register writes, index and data
//
// One command per cycle is sustained while m_tready is high; each command passes from its
// transfer to its result through the input register, the queue and the result register.
// The lock engine is combinational between the queue and the result register, so the rate
// is set by the result register draining at m_tready.
// Reset is synchronous; it locks the bolt, clears the countdowns and ages, saturates the
// motion age and loads the default register values. No clearing pass is needed.
// When m_tready is low the result register, then the two-entry queue, then the input
// register fill before s_tready drops.
module keypad_code_lock_controller #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF,
  parameter int TIMER_BITS  = kcl_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [kcl_pkg::S_TDATA_W-1:0]   s_tdata,  // key_code[3:0], motion_level[4]
  input  logic [kcl_pkg::OPCODE_W-1:0]    s_tuser,  // opcode[2:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // door_locked[0], lockout_active[1], entry_count[4:2], attempts_left[7:5],
  // relock_pending[8]
  output logic [kcl_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [kcl_pkg::EV_W-1:0]        m_tuser,  // event_res[2:0]
  input  logic                            cfg_write,
  input  logic [kcl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kcl_pkg::PIN_W-1:0]       cfg_data
);
  import kcl_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_data;

  kcl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  kcl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_valid),
    .in_ready  (cmd_ready),
    .in_data   (cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  kcl_back #(
    .CODE_DIGITS (CODE_DIGITS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule
